FILE: rtl/rvi_pkg.sv
// Shared types and constants for the ray/voxel intersection length block.
// Used by the controller, the datapath and the serial divider.
package rvi_pkg;

    localparam int MAX_RAYS   = 16;
    localparam int K_W        = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RAYS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_STEP = 3'd4;

    // Serial divider geometry
    localparam int DIV_NW     = 80;
    localparam int DIV_DW     = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

    // Datapath widths
    localparam int QW         = 52;   // signed slab quotient
    localparam int NUM_W      = 38;   // signed slab numerator
    localparam int CHORD_W    = 41;   // chord, saturates at 2^40
    localparam int TOT_W      = CHORD_W + K_W;

    localparam int EPS_Q28    = 26844;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M_START,
        S_M_WAIT,
        S_ZCHK,
        S_POS,
        S_MUL_Y,
        S_MUL_X,
        S_XS,
        S_SLAB_START,
        S_SLAB_WAIT,
        S_CHORD,
        S_COS_WAIT,
        S_NEXT,
        S_FINAL,
        S_W_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_M_START,
        OP_M_FIN,
        OP_POS,
        OP_MUL_Y,
        OP_MUL_X,
        OP_XS,
        OP_SLAB_START,
        OP_SLAB_FIN,
        OP_ADD_D,
        OP_ADD_MAX,
        OP_COS_START,
        OP_COS_FIN,
        OP_NEXT_RAY,
        OP_W_ZERO,
        OP_W_MAX,
        OP_W_START,
        OP_W_FIN,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic div_done;
        logic flat;
        logic z_ok;
        logic slab_last;
        logic d_pos;
        logic d_sat;
        logic ray_last;
        logic thr;
        logic xh_zero;
    } t_status;

endpackage

FILE: rtl/rvi_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on rvi_pkg for its widths.
module rvi_div import rvi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_NW-1:0] o_quo,
    output logic              o_done
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_DW-1:0]    r_rem, n_rem;
    logic [DIV_NW-1:0]    r_quo, n_quo;
    logic [DIV_DW-1:0]    r_den, n_den;

    always_comb begin
        logic [DIV_DW:0] trial;
        logic [DIV_DW:0] diff;
        trial  = {r_rem, r_quo[DIV_NW-1]};
        diff   = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = diff[DIV_DW-1:0];
                n_quo = {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_DW-1:0];
                n_quo = {r_quo[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

FILE: rtl/rvi_datapath.sv
// Datapath: configuration registers, item registers, ray multiplier,
// slab min/max and chord accumulator. Uses rvi_pkg and rvi_div.
module rvi_datapath import rvi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [31:0]    i_center_x,
    input  logic signed [31:0]    i_center_y,
    input  logic signed [31:0]    i_center_z,
    input  logic signed [31:0]    i_tan_theta,
    input  logic [28:0]           i_cos_theta,
    input  logic signed [29:0]    i_dir_cos,
    input  logic signed [29:0]    i_dir_sin,
    input  logic signed [31:0]    i_axial_offset,
    input  logic signed [31:0]    i_tangential_offset,
    input  t_op                   i_op,
    output t_status               o_status,
    output logic [30:0]           o_weight
);

    localparam int SF_W  = 32 + K_W + 2;
    localparam int SUM_W = SF_W + 1;

    localparam logic [2:0] SL_Y_LO = 3'd0;
    localparam logic [2:0] SL_Y_HI = 3'd1;
    localparam logic [2:0] SL_X_LO = 3'd2;
    localparam logic [2:0] SL_X_HI = 3'd3;
    localparam logic [2:0] SL_Z_LO = 3'd4;

    // configuration
    logic [30:0] r_half_x, r_half_y, r_half_z, r_step;
    logic [4:0]  r_num_rays;

    // item
    logic signed [31:0] r_cx, r_cy, r_cz, r_tn, r_t;
    logic signed [32:0] r_sn;
    logic [28:0]        r_ct;
    logic signed [29:0] r_cp, r_sp;
    logic               r_flat;

    // work
    logic signed [35:0]     r_zs;
    logic signed [33:0]     r_pos;
    logic signed [63:0]     r_prod;
    logic signed [35:0]     r_ys, r_xs;
    logic signed [QW-1:0]   r_lo, r_hi;
    logic [2:0]             r_j;
    logic [K_W-1:0]         r_k;
    logic [TOT_W-1:0]       r_total;
    logic [30:0]            r_w, r_weight;
    logic                   r_neg;

    logic                   div_start;
    logic [DIV_NW-1:0]      div_num, div_quo;
    logic [DIV_DW-1:0]      div_den;
    logic                   div_done;
    logic                   div_neg;

    function automatic logic signed [29:0] clamp_dir(input logic signed [29:0] d);
        logic signed [29:0] r;
        r = d;
        if (d < 30'sd26844 && d > -30'sd26844)
            r = d[29] ? -30'sd26844 : 30'sd26844;
        return r;
    endfunction

    // divide by 2^28, rounding toward zero
    function automatic logic signed [34:0] trunc28(input logic signed [63:0] p);
        logic signed [63:0] a;
        a = p + (p[63] ? 64'sd268435455 : 64'sd0);
        return 35'(a >>> 28);
    endfunction

    logic signed [31:0] hx_s, hy_s, hz_s;
    logic [K_W-1:0]     nm1;
    logic signed [QW:0] d_full;
    logic [DIV_NW-1:0]  quo_ext;

    assign hx_s = r_cp[29] ? -$signed({1'b0, r_half_x}) : $signed({1'b0, r_half_x});
    assign hy_s = r_sp[29] ? -$signed({1'b0, r_half_y}) : $signed({1'b0, r_half_y});
    assign hz_s = (!r_flat && r_tn[31]) ? -$signed({1'b0, r_half_z})
                                        : $signed({1'b0, r_half_z});
    assign d_full  = {r_hi[QW-1], r_hi} - {r_lo[QW-1], r_lo};
    assign quo_ext = div_quo;

    always_comb begin
        if (r_num_rays == 5'd0)
            nm1 = '0;
        else if (32'(r_num_rays) > MAX_RAYS)
            nm1 = K_W'(MAX_RAYS - 1);
        else
            nm1 = K_W'(r_num_rays - 5'd1);
    end

    // divider operand selection
    always_comb begin
        logic signed [NUM_W-1:0] num_s;
        logic signed [32:0]      den_s;
        logic [NUM_W-1:0]        num_m;
        num_s     = '0;
        den_s     = '0;
        num_m     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        case (i_op)
            OP_M_START: begin
                div_start = 1'b1;
                num_s     = NUM_W'(r_t);
                num_m     = num_s[NUM_W-1] ? -num_s : num_s;
                div_num   = DIV_NW'({num_m, 28'b0});
                div_den   = DIV_DW'(r_ct);
                div_neg   = r_t[31];
            end
            OP_SLAB_START: begin
                div_start = 1'b1;
                case (r_j)
                    SL_Y_LO: begin
                        num_s = NUM_W'(r_ys) - NUM_W'(hy_s);
                        den_s = 33'(r_sp);
                    end
                    SL_Y_HI: begin
                        num_s = NUM_W'(r_ys) + NUM_W'(hy_s);
                        den_s = 33'(r_sp);
                    end
                    SL_X_LO: begin
                        num_s = NUM_W'(r_xs) - NUM_W'(hx_s);
                        den_s = 33'(r_cp);
                    end
                    SL_X_HI: begin
                        num_s = NUM_W'(r_xs) + NUM_W'(hx_s);
                        den_s = 33'(r_cp);
                    end
                    SL_Z_LO: begin
                        num_s = NUM_W'(r_zs) - NUM_W'(hz_s);
                        den_s = 33'(r_tn);
                    end
                    default: begin
                        num_s = NUM_W'(r_zs) + NUM_W'(hz_s);
                        den_s = 33'(r_tn);
                    end
                endcase
                num_m   = num_s[NUM_W-1] ? -num_s : num_s;
                div_num = DIV_NW'({num_m, 28'b0});
                div_den = DIV_DW'(den_s[32] ? -den_s : den_s);
                div_neg = num_s[NUM_W-1] ^ den_s[32];
            end
            OP_COS_START: begin
                div_start = 1'b1;
                div_num   = DIV_NW'({d_full[CHORD_W-1:0], 28'b0});
                div_den   = DIV_DW'(r_ct);
            end
            OP_W_START: begin
                div_start = 1'b1;
                div_num   = DIV_NW'({r_total, 16'b0});
                div_den   = {r_half_x, 1'b0};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    rvi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_x   <= 31'd131072;
            r_half_y   <= 31'd131072;
            r_half_z   <= 31'd131072;
            r_num_rays <= 5'd1;
            r_step     <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_X:   r_half_x   <= i_cfg_data;
                CFG_HALF_Y:   r_half_y   <= i_cfg_data;
                CFG_HALF_Z:   r_half_z   <= i_cfg_data;
                CFG_NUM_RAYS: r_num_rays <= i_cfg_data[4:0];
                CFG_RAY_STEP: r_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        logic [33:0]             m_mag;
        logic signed [34:0]      m_s;
        logic signed [K_W+1:0]   f;
        logic signed [SF_W-1:0]  sf;
        logic signed [SF_W-1:0]  sf_half;
        logic signed [SUM_W-1:0] sum;
        logic signed [QW-1:0]    qs;
        logic [CHORD_W-1:0]      c_add;
        m_mag   = (quo_ext > DIV_NW'(64'h2_0000_0000)) ? 34'h2_0000_0000 : quo_ext[33:0];
        m_s     = r_neg ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
        f       = $signed({2'b0, r_k} << 1) - $signed({2'b0, nm1});
        sf      = $signed({1'b0, r_step}) * f;
        sf_half = (sf + (sf[SF_W-1] ? SF_W'(1) : SF_W'(0))) >>> 1;
        sum     = SUM_W'(r_sn) + SUM_W'(sf_half);
        qs      = r_neg ? -$signed({1'b0, quo_ext[QW-2:0]})
                        : $signed({1'b0, quo_ext[QW-2:0]});
        c_add   = '0;
        case (i_op)
            OP_LOAD: begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_cz    <= i_center_z;
                r_tn    <= i_tan_theta;
                r_t     <= i_axial_offset;
                r_sn    <= -33'(i_tangential_offset);
                r_ct    <= (i_cos_theta == 29'd0) ? 29'd1 : i_cos_theta;
                r_cp    <= clamp_dir(i_dir_cos);
                r_sp    <= clamp_dir(i_dir_sin);
                r_flat  <= (i_tan_theta < 32'sd26844) && (i_tan_theta > -32'sd26844);
                r_total <= '0;
                r_k     <= '0;
                r_j     <= '0;
            end
            OP_M_FIN: r_zs <= 36'(r_cz) - 36'(m_s);
            OP_POS: begin
                if (sum > SUM_W'(64'sh1_0000_0000))
                    r_pos <= 34'sh1_0000_0000;
                else if (sum < -SUM_W'(64'sh1_0000_0000))
                    r_pos <= -34'sh1_0000_0000;
                else
                    r_pos <= 34'(sum);
            end
            OP_MUL_Y: r_prod <= r_pos * r_cp;
            OP_MUL_X: begin
                r_ys   <= 36'(r_cy) - 36'(trunc28(r_prod));
                r_prod <= r_pos * r_sp;
            end
            OP_XS: r_xs <= 36'(r_cx) + 36'(trunc28(r_prod));
            OP_SLAB_FIN: begin
                case (r_j)
                    SL_Y_LO: r_lo <= qs;
                    SL_Y_HI: r_hi <= qs;
                    SL_X_LO, SL_Z_LO: if (qs > r_lo) r_lo <= qs;
                    default: if (qs < r_hi) r_hi <= qs;
                endcase
                r_j <= r_j + 3'd1;
            end
            OP_ADD_D: begin
                c_add = (d_full > (QW+1)'(64'sh100_0000_0000)) ? CHORD_W'(64'h100_0000_0000)
                                                             : d_full[CHORD_W-1:0];
                r_total <= r_total + TOT_W'(c_add);
            end
            OP_ADD_MAX: r_total <= r_total + TOT_W'(64'h100_0000_0000);
            OP_COS_FIN: begin
                c_add = (quo_ext > DIV_NW'(64'h100_0000_0000)) ? CHORD_W'(64'h100_0000_0000)
                                                             : quo_ext[CHORD_W-1:0];
                r_total <= r_total + TOT_W'(c_add);
            end
            OP_NEXT_RAY: begin
                r_k <= r_k + 1'b1;
                r_j <= '0;
            end
            OP_W_ZERO: r_w <= '0;
            OP_W_MAX:  r_w <= 31'h7FFF_FFFF;
            OP_W_FIN:  r_w <= (quo_ext > DIV_NW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                                : quo_ext[30:0];
            OP_OUT:    r_weight <= r_w;
            default: ;
        endcase
        if (div_start)
            r_neg <= div_neg;
    end

    always_comb begin
        logic [35:0] zs_mag;
        zs_mag             = 36'(r_zs[35] ? -r_zs : r_zs);
        o_status.div_done  = div_done;
        o_status.flat      = r_flat;
        o_status.z_ok      = 36'(r_half_z) > zs_mag;
        o_status.slab_last = (r_j == (r_flat ? SL_X_HI : 3'd5));
        o_status.d_pos     = d_full > 0;
        o_status.d_sat     = d_full >= $signed((QW+1)'({r_ct, 12'b0}));
        o_status.ray_last  = (r_k == nm1);
        o_status.thr       = (55'(r_total) * 55'd1000) > 55'(r_half_x);
        o_status.xh_zero   = (r_half_x == 31'd0);
    end

    assign o_weight = r_weight;

endmodule

FILE: rtl/rvi_ctrl.sv
// Controller state machine: sequences the datapath per transaction and
// owns the input stall and output valid. Uses rvi_pkg types.
module rvi_ctrl import rvi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_M_START;
            S_M_START:    n_state = S_M_WAIT;
            S_M_WAIT:     if (i_status.div_done) n_state = S_ZCHK;
            S_ZCHK:       n_state = (i_status.flat && !i_status.z_ok) ? S_FINAL : S_POS;
            S_POS:        n_state = S_MUL_Y;
            S_MUL_Y:      n_state = S_MUL_X;
            S_MUL_X:      n_state = S_XS;
            S_XS:         n_state = S_SLAB_START;
            S_SLAB_START: n_state = S_SLAB_WAIT;
            S_SLAB_WAIT: begin
                if (i_status.div_done)
                    n_state = i_status.slab_last ? S_CHORD : S_SLAB_START;
            end
            S_CHORD: begin
                if (!i_status.d_pos || i_status.flat || i_status.d_sat)
                    n_state = S_NEXT;
                else
                    n_state = S_COS_WAIT;
            end
            S_COS_WAIT:   if (i_status.div_done) n_state = S_NEXT;
            S_NEXT:       n_state = i_status.ray_last ? S_FINAL : S_POS;
            S_FINAL: begin
                if (i_status.thr && !i_status.xh_zero)
                    n_state = S_W_WAIT;
                else
                    n_state = S_OUT;
            end
            S_W_WAIT:     if (i_status.div_done) n_state = S_OUT;
            S_OUT:        if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_op = OP_NONE;
        case (r_state)
            S_IDLE:       if (i_in_valid) o_op = OP_LOAD;
            // the first divide starts right after the load
            S_M_START:    o_op = OP_M_START;
            S_M_WAIT:     if (i_status.div_done) o_op = OP_M_FIN;
            S_ZCHK:       o_op = OP_NONE;
            S_POS:        o_op = OP_POS;
            S_MUL_Y:      o_op = OP_MUL_Y;
            S_MUL_X:      o_op = OP_MUL_X;
            S_XS:         o_op = OP_XS;
            S_SLAB_START: o_op = OP_SLAB_START;
            S_SLAB_WAIT:  if (i_status.div_done) o_op = OP_SLAB_FIN;
            S_CHORD: begin
                if (!i_status.d_pos)
                    o_op = OP_NONE;
                else if (i_status.flat)
                    o_op = OP_ADD_D;
                else if (i_status.d_sat)
                    o_op = OP_ADD_MAX;
                else
                    o_op = OP_COS_START;
            end
            S_COS_WAIT:   if (i_status.div_done) o_op = OP_COS_FIN;
            S_NEXT:       o_op = OP_NEXT_RAY;
            S_FINAL: begin
                if (!i_status.thr)
                    o_op = OP_W_ZERO;
                else if (i_status.xh_zero)
                    o_op = OP_W_MAX;
                else
                    o_op = OP_W_START;
            end
            S_W_WAIT:     if (i_status.div_done) o_op = OP_W_FIN;
            S_OUT:        if (out_free) o_op = OP_OUT;
            default:      o_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_OUT && out_free)
            n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/ray_voxel_intersection_length.sv
// Ray/voxel intersection length, slab method, Q16.16 lengths, Q4.28 tangent, Q1.28 cos_theta, Q2.28 directions.
// Each ray traced takes 4 slab divides for a flat line and 6 otherwise, all on one
// 80-step serial divider. One transaction at a time: the next item is taken the cycle
// after the result is registered, while that result may still wait in the output register.
// Synchronous active-low reset: configuration registers to defaults, output empty, controller idle.
module ray_voxel_intersection_length import rvi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [31:0]    i_center_x,
    input  logic signed [31:0]    i_center_y,
    input  logic signed [31:0]    i_center_z,
    input  logic signed [31:0]    i_tan_theta,
    input  logic [28:0]           i_cos_theta,
    input  logic signed [29:0]    i_dir_cos,
    input  logic signed [29:0]    i_dir_sin,
    input  logic signed [31:0]    i_axial_offset,
    input  logic signed [31:0]    i_tangential_offset,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [30:0]           o_weight
);

    t_op     op;
    t_status status;

    rvi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_op        (op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rvi_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_center_z          (i_center_z),
        .i_tan_theta         (i_tan_theta),
        .i_cos_theta         (i_cos_theta),
        .i_dir_cos           (i_dir_cos),
        .i_dir_sin           (i_dir_sin),
        .i_axial_offset      (i_axial_offset),
        .i_tangential_offset (i_tangential_offset),
        .i_op                (op),
        .o_status            (status),
        .o_weight            (o_weight)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for ray_voxel_intersection_length.
// Depends on rvi_pkg and the block itself; predicts in fixed point each weight not given as known.
`timescale 1ns / 1ps

module testbench;
    import rvi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint Q28      = 64'sd268435456;
    localparam longint EPS      = 64'sd26844;
    localparam longint M_LIM    = 64'sd1 << 33;
    localparam longint POS_LIM  = 64'sd1 << 32;
    localparam longint CHORD_LIM = 64'sd1 << 40;
    localparam longint W_MAX    = 64'sd2147483647;
    localparam int     LONG_HOLD = 3000;

    typedef struct {
        logic signed [31:0] cx, cy, cz, tn;
        logic        [28:0] ct;
        logic signed [29:0] dc, ds;
        logic signed [31:0] t, s;
        bit                 known;
        logic        [30:0] w;
    } t_line;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic signed [31:0]    i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic signed [31:0]    i_tan_theta = '0;
    logic [28:0]           i_cos_theta = '0;
    logic signed [29:0]    i_dir_cos = '0, i_dir_sin = '0;
    logic signed [31:0]    i_axial_offset = '0, i_tangential_offset = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [30:0]           o_weight;

    ray_voxel_intersection_length i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the registers
    longint hx_reg = 131072, hy_reg = 131072, hz_reg = 131072;
    longint rays_reg = 1, step_reg = 65536;

    logic [30:0] weight_q[$];
    int  errors = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;
    int  hold_left = 0;

    function automatic longint lim(longint v, longint l);
        return (v > l) ? l : ((v < -l) ? -l : v);
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint clamp_small(longint d);
        if (d < EPS && d > -EPS) return d >= 0 ? EPS : -EPS;
        return d;
    endfunction

    function automatic logic [30:0] predict_weight(t_line l);
        longint cx, cy, cz, tn, ct, cp, sp, t, s;
        longint hx, hy, hz, m, zs, n, total, w, pos, ys, xs, lo, hi, d, q, k;
        bit flat;
        cx = l.cx; cy = l.cy; cz = l.cz; tn = l.tn; ct = l.ct;
        cp = l.dc; sp = l.ds; t = l.t; s = l.s;
        total = 0;
        flat = (tn < EPS && tn > -EPS);
        n = rays_reg;
        if (n < 1) n = 1;
        if (n > MAX_RAYS) n = MAX_RAYS;
        if (ct == 0) ct = 1;
        hx = cp >= 0 ? hx_reg : -hx_reg;
        hy = sp >= 0 ? hy_reg : -hy_reg;
        hz = (flat || tn >= 0) ? hz_reg : -hz_reg;
        cp = clamp_small(cp);
        sp = clamp_small(sp);
        m  = lim((t * Q28) / ct, M_LIM);
        zs = cz - m;
        if (!flat || hz_reg - (zs < 0 ? -zs : zs) > 0) begin
            for (k = 0; k < n; k++) begin
                pos = lim(-s + (step_reg * (2 * k - (n - 1))) / 2, POS_LIM);
                ys = cy - (pos * cp) / Q28;
                xs = cx + (pos * sp) / Q28;
                lo = lmax(((ys - hy) * Q28) / sp, ((xs - hx) * Q28) / cp);
                hi = lmin(((ys + hy) * Q28) / sp, ((xs + hx) * Q28) / cp);
                if (!flat) begin
                    lo = lmax(lo, ((zs - hz) * Q28) / tn);
                    hi = lmin(hi, ((zs + hz) * Q28) / tn);
                end
                d = hi - lo;
                if (d > 0) begin
                    if (flat) begin
                        total += (d > CHORD_LIM) ? CHORD_LIM : d;
                    end else begin
                        q = d / ct;
                        if (q >= CHORD_LIM / Q28) begin
                            total += CHORD_LIM;
                        end else begin
                            q = q * Q28 + ((d % ct) * Q28) / ct;
                            total += (q > CHORD_LIM) ? CHORD_LIM : q;
                        end
                    end
                end
            end
        end
        if (total * 1000 > hx_reg) begin
            if (hx_reg == 0) begin
                w = W_MAX;
            end else begin
                w = (total * 65536) / (2 * hx_reg);
                if (w > W_MAX) w = W_MAX;
            end
        end else begin
            w = 0;
        end
        return w[30:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        case (idx)
            CFG_HALF_X:   hx_reg = val & 64'h7FFFFFFF;
            CFG_HALF_Y:   hy_reg = val & 64'h7FFFFFFF;
            CFG_HALF_Z:   hz_reg = val & 64'h7FFFFFFF;
            CFG_NUM_RAYS: rays_reg = val & 64'h1F;
            CFG_RAY_STEP: step_reg = val & 64'h7FFFFFFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic setup(input longint hx, hy, hz, n, st);
        // drop valid and drain everything before touching registers
        i_in_valid = 1'b0;
        while (weight_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        write_reg(CFG_HALF_X, hx);
        write_reg(CFG_HALF_Y, hy);
        write_reg(CFG_HALF_Z, hz);
        write_reg(CFG_NUM_RAYS, n);
        write_reg(CFG_RAY_STEP, st);
    endtask

    // called at a falling edge; returns at a falling edge with the item taken
    task automatic send_line(input t_line l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_center_x = l.cx; i_center_y = l.cy; i_center_z = l.cz;
        i_tan_theta = l.tn; i_cos_theta = l.ct;
        i_dir_cos = l.dc; i_dir_sin = l.ds;
        i_axial_offset = l.t; i_tangential_offset = l.s;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        weight_q.push_back(l.known ? l.w : predict_weight(l));
        @(negedge i_clk);
    endtask

    function automatic logic signed [29:0] rand_dir();
        return 30'($signed($urandom_range(0, 536870912)) - 268435456);
    endfunction

    function automatic t_line random_line();
        t_line l;
        int r;
        l.known = 0;
        l.w = '0;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            // line near a voxel around the origin
            l.cx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            l.cy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            l.cz = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            l.tn = ($urandom_range(0, 2) == 0) ? $signed($urandom_range(0, 40000)) - 20000
                                               : $signed($urandom_range(0, 1 << 28)) - (1 << 27);
            l.ct = 29'($urandom_range(1 << 27, 1 << 28));
            l.t  = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            l.s  = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        end else begin
            l.cx = $urandom; l.cy = $urandom; l.cz = $urandom;
            l.tn = $urandom; l.t = $urandom; l.s = $urandom;
            l.ct = 29'($urandom_range(0, 268435456));
        end
        l.dc = ($urandom_range(0, 9) == 0) ? 30'($signed($urandom_range(0, 60000)) - 30000)
                                           : rand_dir();
        l.ds = ($urandom_range(0, 9) == 0) ? 30'($signed($urandom_range(0, 60000)) - 30000)
                                           : rand_dir();
        return l;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) send_line(random_line());
    endtask

    // directed table: extremes, both slab modes, clamps and saturations
    t_line dir_tab[$];

    function automatic t_line mk(int cx, cy, cz, tn, ct, dc, ds, t, s);
        t_line l;
        l.cx = cx; l.cy = cy; l.cz = cz; l.tn = tn; l.ct = 29'(ct);
        l.dc = 30'(dc); l.ds = 30'(ds); l.t = t; l.s = s; l.known = 0; l.w = '0;
        return l;
    endfunction

    initial begin
        t_line l;
        // flat line far outside the z extent: nothing traced
        l = mk(0, 0, 32'h7FFFFFFF, 0, 1 << 28, 1 << 28, 0, 0, 0);
        l.known = 1; l.w = '0;
        dir_tab.push_back(l);
        l = mk(32'h80000000, 0, 32'h80000000, 0, 1 << 28, 0, 1 << 28, 0, 0);
        l.known = 1; l.w = '0;
        dir_tab.push_back(l);
        dir_tab.push_back(mk(0, 0, 0, 0, 1 << 28, 1 << 28, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 0, 1 << 28, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 1 << 26, 1 << 28, 1 << 27, 1 << 27, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, -(1 << 26), 1 << 28, -(1 << 27), -(1 << 27), 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 26843, 1 << 28, -(1 << 28), 1 << 20, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, -26843, 1 << 28, 26843, -26843, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 26844, 1 << 28, 1 << 28, 1 << 28, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, -26844, 1 << 28, 1 << 28, -(1 << 28), 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 32'h7FFFFFFF, 1 << 28, 1 << 27, 1 << 27, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 32'h80000000, 1 << 28, 1 << 27, 1 << 27, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 1 << 26, 0, 1 << 27, 1 << 27, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 1 << 26, 1, 1 << 27, 1 << 27, 32'h7FFFFFFF, 0));
        dir_tab.push_back(mk(0, 0, 0, 1 << 26, 1, 1 << 27, 1 << 27, 32'h80000000, 0));
        dir_tab.push_back(mk(0, 0, 0, 0, 1 << 28, 1 << 27, 1 << 27, 0, 32'h7FFFFFFF));
        dir_tab.push_back(mk(0, 0, 0, 0, 1 << 28, 1 << 27, 1 << 27, 0, 32'h80000000));
        dir_tab.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1 << 20, 1 << 28,
                             1 << 28, 1 << 28, 0, 0));
        dir_tab.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                             29'h1FFFFFFF >> 1, -1, -1, -1, -1));
        dir_tab.push_back(mk(65536, -65536, 0, 0, 1 << 28, 1 << 27, -(1 << 27),
                             0, 40000));
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        int r;
        if (hold_req) begin
            hold_req = 0;
            hold_left = LONG_HOLD;
        end
        r = $urandom_range(0, 99);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else if (r < 8) begin
            hold_left = $urandom_range(10, 50);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (r < 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (weight_q.size() == 0) begin
                $error("weight: unexpected transaction, actual %0d", o_weight);
                errors++;
            end else begin
                logic [30:0] exp_w;
                exp_w = weight_q.pop_front();
                if (o_weight !== exp_w) begin
                    $error("weight: expected %0d, actual %0d", exp_w, o_weight);
                    errors++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) send_line(dir_tab[i]);

        setup(131072, 131072, 131072, 1, 65536);
        run_random(300);
        no_idle = 1;
        run_random(100);
        no_idle = 0;

        setup(1, 64'h7FFFFFFF, 64'h7FFFFFFF, 2, 0);
        run_random(200);

        setup(64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 0, 64'h7FFFFFFF);
        run_random(150);

        setup(65536, 196608, 262144, 4, 32768);
        hold_req = 1;
        run_random(120);

        setup(131072, 131072, 131072, 31, 16384);
        run_random(25);

        setup(98304, 65536, 131072, 16, 1);
        run_random(15);

        setup(32768, 1 << 20, 1 << 18, 1, 65536);
        write_reg(CFG_UNUSED, 64'h7FFFFFFF);
        hold_req = 1;
        run_random(500);

        setup(1 << 17, 1 << 16, 1 << 17, 3, 1 << 16);
        run_random(150);

        i_in_valid = 1'b0;
        while (weight_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

FILE: ray_voxel_intersection_length.f
rtl/rvi_pkg.sv
rtl/rvi_div.sv
rtl/rvi_datapath.sv
rtl/rvi_ctrl.sv
rtl/ray_voxel_intersection_length.sv
test/testbench.sv
